[design/grr_pkg.sv]
`timescale 1ns / 1ps

package grr_pkg;

  localparam int CODE_W = 8;
  localparam int ROW_W = 4;
  localparam int COLOR_W = 16;
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam int GCOL_W = $clog2(GLYPH_COLS);
  localparam int GROW_W = $clog2(GLYPH_ROWS);
  localparam int FONT_IDX_W = 7;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CODE_W-1:0] FIRST_CODE = 8'd32;

  localparam logic [CFG_INDEX_W-1:0] REG_FG_COLOR = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BG_COLOR = 1'd1;

  typedef logic [GLYPH_COLS-1:0] glyph_mask_t;

  typedef struct packed {
    glyph_mask_t mask;
  } row_entry_t;

  typedef struct packed {
    logic       empty;
    row_entry_t entry;
  } queue_rd_t;

  // Five font columns packed with column 0 in the low byte; bit r of a byte is glyph row r.
  function automatic logic [8*GLYPH_COLS-1:0] font_columns(input logic [FONT_IDX_W-1:0] idx);
    logic [8*GLYPH_COLS-1:0] word;
    begin
      case (idx)
        7'd1:  word = 40'h00_00_4f_00_00;
        7'd2:  word = 40'h00_07_00_07_00;
        7'd3:  word = 40'h14_7f_14_7f_14;
        7'd4:  word = 40'h12_2a_7f_2a_24;
        7'd5:  word = 40'h62_64_08_13_23;
        7'd6:  word = 40'h50_22_55_49_36;
        7'd7:  word = 40'h00_00_03_05_00;
        7'd8:  word = 40'h00_41_22_1c_00;
        7'd9:  word = 40'h00_1c_22_41_00;
        7'd10: word = 40'h14_08_3e_08_14;
        7'd11: word = 40'h08_08_3e_08_08;
        7'd12: word = 40'h00_00_30_50_00;
        7'd13: word = 40'h08_08_08_08_08;
        7'd14: word = 40'h00_00_60_60_00;
        7'd15: word = 40'h02_04_08_10_20;
        7'd16: word = 40'h3e_45_49_51_3e;
        7'd17: word = 40'h00_40_7f_42_00;
        7'd18: word = 40'h46_49_51_61_42;
        7'd19: word = 40'h31_4b_45_41_21;
        7'd20: word = 40'h10_7f_12_14_18;
        7'd21: word = 40'h39_45_45_45_27;
        7'd22: word = 40'h30_49_49_4a_3c;
        7'd23: word = 40'h03_05_09_71_01;
        7'd24: word = 40'h36_49_49_49_36;
        7'd25: word = 40'h1e_29_49_49_06;
        7'd26: word = 40'h00_00_36_36_00;
        7'd27: word = 40'h00_00_36_56_00;
        7'd28: word = 40'h00_41_22_14_08;
        7'd29: word = 40'h14_14_14_14_14;
        7'd30: word = 40'h08_14_22_41_00;
        7'd31: word = 40'h06_09_51_01_02;
        7'd32: word = 40'h3e_41_79_49_32;
        7'd33: word = 40'h7e_11_11_11_7e;
        7'd34: word = 40'h36_49_49_49_7f;
        7'd35: word = 40'h22_41_41_41_3e;
        7'd36: word = 40'h1c_22_41_41_7f;
        7'd37: word = 40'h41_49_49_49_7f;
        7'd38: word = 40'h01_09_09_09_7f;
        7'd39: word = 40'h7a_49_49_41_3e;
        7'd40: word = 40'h7f_08_08_08_7f;
        7'd41: word = 40'h00_41_7f_41_00;
        7'd42: word = 40'h01_3f_41_40_20;
        7'd43: word = 40'h41_22_14_08_7f;
        7'd44: word = 40'h40_40_40_40_7f;
        7'd45: word = 40'h7f_02_0c_02_7f;
        7'd46: word = 40'h7f_10_08_04_7f;
        7'd47: word = 40'h3e_41_41_41_3e;
        7'd48: word = 40'h06_09_09_09_7f;
        7'd49: word = 40'h5e_21_51_41_3e;
        7'd50: word = 40'h46_29_19_09_7f;
        7'd51: word = 40'h31_49_49_49_46;
        7'd52: word = 40'h01_01_7f_01_01;
        7'd53: word = 40'h3f_40_40_40_3f;
        7'd54: word = 40'h1f_20_40_20_1f;
        7'd55: word = 40'h3f_40_38_40_3f;
        7'd56: word = 40'h63_14_08_14_63;
        7'd57: word = 40'h07_08_70_08_07;
        7'd58: word = 40'h43_45_49_51_61;
        7'd59: word = 40'h00_41_41_7f_00;
        7'd60: word = 40'h20_10_08_04_02;
        7'd61: word = 40'h00_7f_41_41_00;
        7'd62: word = 40'h04_02_01_02_04;
        7'd63: word = 40'h40_40_40_40_40;
        7'd64: word = 40'h00_04_02_01_00;
        7'd65: word = 40'h78_54_54_54_20;
        7'd66: word = 40'h38_44_44_48_7f;
        7'd67: word = 40'h20_44_44_44_38;
        7'd68: word = 40'h7f_48_44_44_38;
        7'd69: word = 40'h18_54_54_54_38;
        7'd70: word = 40'h02_01_09_7e_08;
        7'd71: word = 40'h3e_52_52_52_0c;
        7'd72: word = 40'h78_04_04_08_7f;
        7'd73: word = 40'h00_40_7d_44_00;
        7'd74: word = 40'h00_3d_44_40_20;
        7'd75: word = 40'h00_44_28_10_7f;
        7'd76: word = 40'h00_40_7f_41_00;
        7'd77: word = 40'h78_04_18_04_7c;
        7'd78: word = 40'h78_04_04_08_7c;
        7'd79: word = 40'h38_44_44_44_38;
        7'd80: word = 40'h08_14_14_14_7c;
        7'd81: word = 40'h7c_18_14_14_08;
        7'd82: word = 40'h08_04_04_08_7c;
        7'd83: word = 40'h20_54_54_54_48;
        7'd84: word = 40'h20_40_44_3f_04;
        7'd85: word = 40'h7c_20_40_40_3c;
        7'd86: word = 40'h1c_20_40_20_1c;
        7'd87: word = 40'h3c_40_30_40_3c;
        7'd88: word = 40'h44_28_10_28_44;
        7'd89: word = 40'h7c_a0_a0_a0_1c;
        7'd90: word = 40'h44_4c_54_64_44;
        7'd91: word = 40'h00_41_36_08_00;
        7'd92: word = 40'h00_00_7f_00_00;
        7'd93: word = 40'h00_08_36_41_00;
        7'd94: word = 40'h08_10_08_08_10;
        default: word = '0;
      endcase
      return word;
    end
  endfunction

endpackage

[design/grr_front.sv]
`timescale 1ns / 1ps

module grr_front (
  input  logic                          push,
  input  logic                          q_full,
  input  logic [grr_pkg::CODE_W-1:0]    char_code,
  input  logic [grr_pkg::ROW_W-1:0]     cell_row,
  output logic                          full,
  output logic                          q_write,
  output grr_pkg::row_entry_t           q_entry
);

  logic [grr_pkg::FONT_IDX_W-1:0]        font_idx;
  logic [8*grr_pkg::GLYPH_COLS-1:0]      columns;
  logic [grr_pkg::GROW_W-1:0]            glyph_row;
  logic                                  printable;
  logic                                  row_in_glyph;
  logic [grr_pkg::CODE_W-1:0]            code_offset;

  assign full    = q_full;
  assign q_write = push && !q_full;

  // Codes below the first printable one or with the top bit set map to space.
  assign printable   = !char_code[7] && (char_code[6:5] != 2'b00);
  assign code_offset = char_code - grr_pkg::FIRST_CODE;
  assign font_idx    = printable ? code_offset[grr_pkg::FONT_IDX_W-1:0] : '0;
  assign columns     = grr_pkg::font_columns(font_idx);

  assign glyph_row    = cell_row[grr_pkg::ROW_W-1:1];
  assign row_in_glyph = glyph_row < grr_pkg::GROW_W'(grr_pkg::GLYPH_ROWS);

  always_comb begin
    q_entry = '0;
    for (int c = 0; c < grr_pkg::GLYPH_COLS; c++) begin
      q_entry.mask[c] = row_in_glyph && columns[c*8 +: 8][glyph_row];
    end
  end

endmodule

[design/grr_queue.sv]
`timescale 1ns / 1ps

module grr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                write,
  input  grr_pkg::row_entry_t wr_entry,
  input  logic                read,
  output logic                full,
  output grr_pkg::queue_rd_t  rd
);

  grr_pkg::row_entry_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign rd.empty = count == 2'd0;
  assign rd.entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (write) begin
      entries[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (write) begin
        wr_ptr <= !wr_ptr;
      end
      if (read) begin
        rd_ptr <= !rd_ptr;
      end
      case ({write, read})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/grr_back.sv]
`timescale 1ns / 1ps

module grr_back #(
  parameter int CELL_WIDTH = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  grr_pkg::queue_rd_t            q_rd,
  output logic                          q_read,
  input  logic [grr_pkg::COLOR_W-1:0]   fg_color,
  input  logic [grr_pkg::COLOR_W-1:0]   backdrop_color,
  input  logic                          pop,
  output logic                          empty,
  output logic [grr_pkg::COLOR_W-1:0]   pixel_rgb,
  output logic                          last_pixel
);

  localparam int COL_W = $clog2(CELL_WIDTH);

  logic                        busy;
  logic [COL_W-1:0]            col;
  grr_pkg::glyph_mask_t        mask;
  logic                        out_valid;

  logic                        out_free;
  logic                        emit;
  logic                        last_col;
  logic                        load;
  logic [grr_pkg::GCOL_W-1:0]  glyph_col;
  logic                        lit;

  assign empty     = !out_valid;
  assign out_free  = !out_valid || pop;
  assign emit      = busy && out_free;
  assign last_col  = col == COL_W'(CELL_WIDTH - 1);
  assign load      = !q_rd.empty && (!busy || (emit && last_col));
  assign q_read    = load;

  assign glyph_col = col[grr_pkg::GCOL_W:1];
  assign lit       = (glyph_col < grr_pkg::GCOL_W'(grr_pkg::GLYPH_COLS)) && mask[glyph_col];

  always_ff @(posedge clk) begin
    if (load) begin
      mask <= q_rd.entry.mask;
    end
    if (emit) begin
      pixel_rgb  <= lit ? fg_color : backdrop_color;
      last_pixel <= last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        col  <= '0;
      end else if (emit) begin
        col <= col + COL_W'(1);
        if (last_col) begin
          busy <= 1'b0;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/glyph_row_rasterizer.sv]
`timescale 1ns / 1ps

// Text character generator that turns one pixel row of one character cell into pixel colors.
// Input channel: push with char_code and cell_row; a transaction completes when push is high
// and full is low. Result channel: while empty is low the oldest pixel sits on pixel_rgb and
// last_pixel, and pop takes it. Each input transaction yields CELL_WIDTH results, left to
// right, with last_pixel set on the rightmost one.
// Configuration: cfg_valid with cfg_index and cfg_data writes fg_color (index 0) or
// backdrop_color (index 1); cfg_ready is always high. Write colors only while no row is in
// flight.
// An accepted row goes through the queue and the back end's mask register to pixel_rgb.
// Throughput: one pixel per cycle while pop keeps the output free and rows are queued, set by
// the single pixel serializer in the back end. The font lookup runs in the front end in the
// accepting cycle, and a two-entry queue between front and back lets push proceed while a row
// is drawn. When the receiver stalls, the current pixel holds and the serializer waits; the
// queue then fills and full rises. Reset empties the queue and the output register and clears
// both colors to zero; there is no clearing pass.
module glyph_row_rasterizer #(
  parameter int CELL_WIDTH = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [grr_pkg::CODE_W-1:0]        char_code,
  input  logic [grr_pkg::ROW_W-1:0]         cell_row,
  output logic                              empty,
  input  logic                              pop,
  output logic [grr_pkg::COLOR_W-1:0]       pixel_rgb,
  output logic                              last_pixel,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [grr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [grr_pkg::COLOR_W-1:0]       cfg_data
);

  logic [grr_pkg::COLOR_W-1:0] fg_color;
  logic [grr_pkg::COLOR_W-1:0] backdrop_color;

  logic                 q_full;
  logic                 q_write;
  grr_pkg::row_entry_t  q_entry;
  grr_pkg::queue_rd_t   q_rd;
  logic                 q_read;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color       <= '0;
      backdrop_color <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        grr_pkg::REG_FG_COLOR: fg_color <= cfg_data;
        grr_pkg::REG_BG_COLOR: backdrop_color <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  grr_front u_front (
    .push      (push),
    .q_full    (q_full),
    .char_code (char_code),
    .cell_row  (cell_row),
    .full      (full),
    .q_write   (q_write),
    .q_entry   (q_entry)
  );

  grr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .write    (q_write),
    .wr_entry (q_entry),
    .read     (q_read),
    .full     (q_full),
    .rd       (q_rd)
  );

  grr_back #(
    .CELL_WIDTH (CELL_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_rd           (q_rd),
    .q_read         (q_read),
    .fg_color       (fg_color),
    .backdrop_color (backdrop_color),
    .pop            (pop),
    .empty          (empty),
    .pixel_rgb      (pixel_rgb),
    .last_pixel     (last_pixel)
  );

endmodule
